// ===== sv/rbcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rbcc_pkg
// Shared widths, defaults and beat types for the comparison-count ranker.
// ----------------------------------------------------------------------------
package rbcc_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int VALUE_W       = 32;
  localparam int RANK_W        = 6;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      is_last;
  } in_beat_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              last_of_run;
    logic              overflowed;
  } out_beat_t;

endpackage

// ===== sv/rbcc_in_if.sv =====
// ----------------------------------------------------------------------------
// rbcc_in_if
// Value channel: one signed value per beat, the final one of a set marked.
// ----------------------------------------------------------------------------
interface rbcc_in_if;
  import rbcc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

// ===== sv/rbcc_out_if.sv =====
// ----------------------------------------------------------------------------
// rbcc_out_if
// Rank channel: one rank per beat, the final one of a run marked.
// ----------------------------------------------------------------------------
interface rbcc_out_if;
  import rbcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;
  logic              last_of_run;
  logic              overflowed;

  modport source (output valid, output rank, output last_of_run, output overflowed,
                  input ready);
  modport sink   (input valid, input rank, input last_of_run, input overflowed,
                  output ready);
endinterface

// ===== sv/rbcc_store.sv =====
// ----------------------------------------------------------------------------
// rbcc_store
// Value memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rbcc_store #(
  parameter int MAX_ITEMS = rbcc_pkg::MAX_ITEMS_DEF,
  parameter int AW        = $clog2(MAX_ITEMS)
) (
  input  logic                               clk,
  input  logic                               we,
  input  logic [AW-1:0]                      waddr,
  input  logic signed [rbcc_pkg::VALUE_W-1:0] wdata,
  input  logic [AW-1:0]                      raddr_a,
  input  logic [AW-1:0]                      raddr_b,
  output logic signed [rbcc_pkg::VALUE_W-1:0] rdata_a,
  output logic signed [rbcc_pkg::VALUE_W-1:0] rdata_b
);
  import rbcc_pkg::*;

  logic signed [VALUE_W-1:0] mem [MAX_ITEMS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== sv/rbcc_seq.sv =====
// ----------------------------------------------------------------------------
// rbcc_seq
// Load/scan sequencer: stores values, then for each stored value counts the
// smaller ones over a memory scan and emits the rank through an output register.
// ----------------------------------------------------------------------------
module rbcc_seq #(
  parameter int MAX_ITEMS = rbcc_pkg::MAX_ITEMS_DEF,
  parameter int AW        = $clog2(MAX_ITEMS),
  parameter int CW        = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rbcc_pkg::in_beat_t                  in_beat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rbcc_pkg::out_beat_t                 out_beat,
  output logic                                we,
  output logic [AW-1:0]                       waddr,
  output logic signed [rbcc_pkg::VALUE_W-1:0] wdata,
  output logic [AW-1:0]                       raddr_a,
  output logic [AW-1:0]                       raddr_b,
  input  logic signed [rbcc_pkg::VALUE_W-1:0] rdata_a,
  input  logic signed [rbcc_pkg::VALUE_W-1:0] rdata_b
);
  import rbcc_pkg::*;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic              ovf;
  logic [AW-1:0]     idx;
  logic [CW-1:0]     j;
  logic              pend;
  logic [AW-1:0]     cnt;
  logic [RANK_W-1:0] rank_w;

  logic accept;
  logic room;
  logic issue;
  logic done;
  logic emit;
  logic run_end;

  generate
    if (AW >= RANK_W) begin : g_rank_cut
      assign rank_w = cnt[RANK_W-1:0];
    end else begin : g_rank_ext
      assign rank_w = RANK_W'(cnt);
    end
  endgenerate

  always_comb begin
    in_ready = (state == ST_LOAD);
    accept   = in_valid && in_ready;
    room     = (count < CW'(MAX_ITEMS));
    we       = accept && room;
    waddr    = count[AW-1:0];
    wdata    = in_beat.value;
    issue    = (state == ST_SCAN) && (j < count);
    raddr_a  = idx;
    raddr_b  = j[AW-1:0];
    done     = (state == ST_SCAN) && !issue && !pend;
    emit     = done && (!out_valid || out_ready);
    run_end  = emit && ((CW'(idx) + CW'(1)) == count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      count     <= '0;
      ovf       <= 1'b0;
      idx       <= '0;
      j         <= '0;
      pend      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      pend <= issue;
      unique case (state)
        ST_LOAD: begin
          if (accept) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              ovf <= 1'b1;
            end
            if (in_beat.is_last) begin
              state <= ST_SCAN;
              idx   <= '0;
              j     <= '0;
              cnt   <= '0;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            j <= j + CW'(1);
          end
          // read data comes from the address issued in the previous cycle
          if (pend && (rdata_b < rdata_a)) begin
            cnt <= cnt + AW'(1);
          end
          if (emit) begin
            cnt       <= '0;
            j         <= '0;
            if (run_end) begin
              state <= ST_LOAD;
              count <= '0;
              ovf   <= 1'b0;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  // payload of the output register, loaded with each rank
  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat.rank        <= rank_w;
      out_beat.last_of_run <= run_end;
      out_beat.overflowed  <= ovf;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ITEMS))
    else $error("stored count above capacity");

  a_scan_idx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(idx) < count))
    else $error("scan position beyond stored values");

  a_smaller: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(cnt) < count))
    else $error("smaller count reached set size");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    run_end |=> ((state == ST_LOAD) && (count == '0) && !ovf))
    else $error("store not emptied after run");

endmodule

// ===== sv/rank_by_comparison_count.sv =====
// ----------------------------------------------------------------------------
// rank_by_comparison_count
// Loads a set of signed values and emits, in load order, each value's rank:
// the count of stored values strictly smaller than it.
//
//   port    dir   beat contents
//   items   in    value (s32), is_last
//   ranks   out   rank (6b), last_of_run, overflowed
//
// items is always ready while loading. For each stored value, a run scans all
// stored entries through one read port of the value memory while the other
// holds that value, counts the last read result and registers the rank.
// items stalls during the run; a stalled rank holds back the next rank.
// rst is synchronous and clears the control state; the memory is not cleared.
// ----------------------------------------------------------------------------
module rank_by_comparison_count #(
  parameter int MAX_ITEMS = rbcc_pkg::MAX_ITEMS_DEF
) (
  input logic     clk,
  input logic     rst,
  rbcc_in_if.sink   items,
  rbcc_out_if.source ranks
);
  import rbcc_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  in_beat_t                  in_beat;
  out_beat_t                 out_beat;
  logic                      out_valid;
  logic                      we;
  logic [AW-1:0]             waddr;
  logic signed [VALUE_W-1:0] wdata;
  logic [AW-1:0]             raddr_a;
  logic [AW-1:0]             raddr_b;
  logic signed [VALUE_W-1:0] rdata_a;
  logic signed [VALUE_W-1:0] rdata_b;
  logic                      in_ready;

  assign in_beat.value   = items.value;
  assign in_beat.is_last = items.is_last;
  assign items.ready     = in_ready;

  assign ranks.valid       = out_valid;
  assign ranks.rank        = out_beat.rank;
  assign ranks.last_of_run = out_beat.last_of_run;
  assign ranks.overflowed  = out_beat.overflowed;

  rbcc_seq #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW),
    .CW        (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (ranks.ready),
    .out_beat  (out_beat),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr_a   (raddr_a),
    .raddr_b   (raddr_b),
    .rdata_a   (rdata_a),
    .rdata_b   (rdata_b)
  );

  rbcc_store #(
    .MAX_ITEMS (MAX_ITEMS),
    .AW        (AW)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule
